>>> design/gopi_pkg.sv
// Shared types, constants and helpers for the gyro odometry pose integrator.
package gopi_pkg;

  localparam int NUM_REGS = 6;
  localparam logic [2:0] REG_X     = 3'd0;
  localparam logic [2:0] REG_Y     = 3'd1;
  localparam logic [2:0] REG_Z     = 3'd2;
  localparam logic [2:0] REG_ROLL  = 3'd3;
  localparam logic [2:0] REG_PITCH = 3'd4;
  localparam logic [2:0] REG_YAW   = 3'd5;

  localparam logic OP_INTEG = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam int FIFO_DEPTH = 2;

  localparam logic signed [34:0] PI_Q28      = 35'sd843314857;
  localparam logic signed [34:0] TWO_PI_Q28  = 35'sd1686629714;
  localparam logic signed [34:0] HALF_PI_Q28 = 35'sd421657428;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032875;

  localparam int ATAN_LEN = 30;
  localparam int ATAN_IW  = 5;

  localparam logic [19:0] DIV_ANGLE = 20'd62500;
  localparam logic [19:0] DIV_DIST  = 20'd1000000;

  typedef struct packed {
    logic        opcode;
    logic [31:0] dt;
    logic [31:0] rate_roll;
    logic [31:0] rate_pitch;
    logic [31:0] rate_yaw;
    logic [31:0] speed;
  } item_t;

  typedef logic [NUM_REGS-1:0][31:0] cfg_regs_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WAIT,
    ST_TRIG_LOAD,
    ST_FOLD,
    ST_ROT,
    ST_TRIG_STORE,
    ST_MQ_LO,
    ST_MQ_HI,
    ST_MQ_SUM,
    ST_OUT
  } back_state_t;

  function automatic logic [27:0] atan_q28(input logic [ATAN_IW-1:0] i);
    logic [27:0] v;
    case (i)
      5'd0:  v = 28'd210828714;
      5'd1:  v = 28'd124459457;
      5'd2:  v = 28'd65760959;
      5'd3:  v = 28'd33381290;
      5'd4:  v = 28'd16755422;
      5'd5:  v = 28'd8385879;
      5'd6:  v = 28'd4193963;
      5'd7:  v = 28'd2097109;
      5'd8:  v = 28'd1048571;
      5'd9:  v = 28'd524287;
      5'd10: v = 28'd262144;
      5'd11: v = 28'd131072;
      5'd12: v = 28'd65536;
      5'd13: v = 28'd32768;
      5'd14: v = 28'd16384;
      5'd15: v = 28'd8192;
      5'd16: v = 28'd4096;
      5'd17: v = 28'd2048;
      5'd18: v = 28'd1024;
      5'd19: v = 28'd512;
      5'd20: v = 28'd256;
      5'd21: v = 28'd128;
      5'd22: v = 28'd64;
      5'd23: v = 28'd32;
      5'd24: v = 28'd16;
      5'd25: v = 28'd8;
      5'd26: v = 28'd4;
      5'd27: v = 28'd2;
      5'd28: v = 28'd1;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

>>> design/gopi_front.sv
// Front end: accepts samples, measures the time step and classifies the opcode.
module gopi_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                opcode,
  input  logic [31:0]         time_us,
  input  logic [31:0]         rate_roll,
  input  logic [31:0]         rate_pitch,
  input  logic [31:0]         rate_yaw,
  input  logic [31:0]         speed,
  input  logic                q_full,
  output logic                q_push,
  output gopi_pkg::item_t     q_din
);
  import gopi_pkg::*;

  logic [31:0] last_time;
  logic        seen_first;

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_din.opcode     = opcode;
    q_din.dt         = (opcode == OP_CLEAR || !seen_first) ? 32'd0 : (time_us - last_time);
    q_din.rate_roll  = rate_roll;
    q_din.rate_pitch = rate_pitch;
    q_din.rate_yaw   = rate_yaw;
    q_din.speed      = speed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time  <= 32'd0;
      seen_first <= 1'b0;
    end else if (q_push) begin
      if (opcode == OP_CLEAR) begin
        last_time  <= 32'd0;
        seen_first <= 1'b0;
      end else begin
        last_time  <= time_us;
        seen_first <= 1'b1;
      end
    end
  end

endmodule

>>> design/gopi_fifo.sv
// Short word queue between the front end and the back end.
module gopi_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gopi_pkg::item_t din,
  output logic            full,
  input  logic            pop,
  output gopi_pkg::item_t dout,
  output logic            empty
);
  import gopi_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  item_t         mem [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/gopi_div.sv
// Constant divider by 62500 or 1000000: power-of-two shift, then 16-bit digits by 15625.
module gopi_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [19:0] divisor,
  output logic        done,
  output logic [63:0] quot
);
  import gopi_pkg::*;

  localparam int NUM_DIGITS = 4;
  localparam int CW = $clog2(NUM_DIGITS);
  localparam int SHIFT_ANGLE = 2;
  localparam int SHIFT_DIST = 6;
  localparam logic [13:0] DIV_CORE = 14'd15625;
  // ceil(2^44 / 15625); exact for partial dividends below 15625 * 2^16
  localparam logic [30:0] RECIP = 31'd1125899907;

  logic [63:0]   num;
  logic [13:0]   rem;
  logic [59:0]   xprod;
  logic [CW-1:0] cnt;
  logic          phase;
  logic          busy;
  logic [29:0]   xw;
  logic [15:0]   qd;

  // remainder and next digit form the partial dividend; quotient digits shift in below
  assign quot = num;
  assign xw   = {rem, num[63:48]};
  assign qd   = xprod[59:44];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num   <= (divisor == DIV_DIST) ? (dividend >> SHIFT_DIST) : (dividend >> SHIFT_ANGLE);
        rem   <= 14'd0;
        cnt   <= '0;
        phase <= 1'b0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (!phase) begin
          xprod <= 60'(xw) * 60'(RECIP);
          phase <= 1'b1;
        end else begin
          num   <= {num[47:0], qd};
          rem   <= 14'(xw - 30'(qd) * 30'(DIV_CORE));
          cnt   <= cnt + 1'b1;
          phase <= 1'b0;
          if (cnt == CW'(NUM_DIGITS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> design/gopi_back.sv
// Back end: sequencer, shared multiplier, CORDIC; drives divider; holds offsets and result.
module gopi_back #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  gopi_pkg::cfg_regs_t cfg,
  input  logic                q_empty,
  input  gopi_pkg::item_t     q_dout,
  output logic                q_pop,
  output logic                div_start,
  output logic [63:0]         div_dividend,
  output logic [19:0]         div_divisor,
  input  logic                div_done,
  input  logic [63:0]         div_quot,
  input  logic                pop,
  output logic                empty,
  output logic signed [31:0]  guess_x,
  output logic signed [31:0]  guess_y,
  output logic signed [31:0]  guess_z,
  output logic signed [31:0]  guess_roll,
  output logic signed [31:0]  guess_pitch,
  output logic signed [31:0]  guess_yaw
);
  import gopi_pkg::*;

  back_state_t state, state_next;

  item_t                 item;
  logic [1:0]            k;
  logic [1:0]            j;
  logic [63:0]           prod;
  logic [63:0]           lo_prod;
  logic signed [31:0]    off_angle [3];
  logic signed [31:0]    off_pos [3];
  logic signed [44:0]    d;
  logic signed [48:0]    horiz;
  logic signed [34:0]    z;
  logic signed [33:0]    x;
  logic signed [33:0]    y;
  logic [ATAN_IW-1:0]    ci;
  logic                  flip;
  logic                  trig_sel;
  logic signed [33:0]    cp, sp, cy, sy;
  logic                  out_valid;

  logic [31:0]           op_v;
  logic signed [63:0]    qs;
  logic signed [31:0]    ang_sum;
  logic signed [34:0]    ta;
  logic signed [48:0]    ma;
  logic signed [33:0]    mb;
  logic [48:0]           ua_full;
  logic [33:0]           ub_full;
  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [63:0]           r_mag;
  logic [63:0]           r8_mag;
  logic                  mq_neg;
  logic signed [63:0]    r_s;
  logic signed [63:0]    r8_s;
  logic [1:0]            pidx;
  logic signed [33:0]    dx, dy;
  logic signed [34:0]    at;

  assign empty = !out_valid;

  always_comb begin
    case (k)
      2'd0:    op_v = item.rate_roll;
      2'd1:    op_v = item.rate_pitch;
      2'd2:    op_v = item.rate_yaw;
      default: op_v = item.speed;
    endcase
  end

  assign qs      = op_v[31] ? -$signed(div_quot) : $signed(div_quot);
  assign ang_sum = sat32(64'(off_angle[k]) + qs);

  assign ta = trig_sel ? (35'($signed(cfg[REG_YAW])) + 35'(off_angle[2]))
                       : (35'($signed(cfg[REG_PITCH])) + 35'(off_angle[1]));

  always_comb begin
    case (j)
      2'd0: begin
        ma = 49'(d);
        mb = cp;
      end
      2'd1: begin
        ma = horiz;
        mb = cy;
      end
      2'd2: begin
        ma = horiz;
        mb = sy;
      end
      default: begin
        ma = 49'(d);
        mb = -sp;
      end
    endcase
  end

  assign ua_full = ma[48] ? 49'(-ma) : 49'(ma);
  assign ub_full = mb[33] ? 34'(-mb) : 34'(mb);
  assign mq_neg  = ma[48] ^ mb[33];

  always_comb begin
    case (state)
      ST_MUL: begin
        mul_a = mag32(op_v);
        mul_b = item.dt;
      end
      ST_MQ_LO: begin
        mul_a = ua_full[31:0];
        mul_b = ub_full[31:0];
      end
      ST_MQ_HI: begin
        mul_a = {16'd0, ua_full[47:32]};
        mul_b = ub_full[31:0];
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign r_mag  = (prod << 2) + ((lo_prod + 64'd536870912) >> 30);
  assign r8_mag = (r_mag + 64'd128) >> 8;
  assign r_s    = mq_neg ? -$signed(r_mag) : $signed(r_mag);
  assign r8_s   = mq_neg ? -$signed(r8_mag) : $signed(r8_mag);
  assign pidx   = j - 2'd1;

  assign dx = y >>> ci;
  assign dy = x >>> ci;
  assign at = 35'($signed({1'b0, atan_q28(ci)}));

  assign div_start    = (state == ST_DIV);
  assign div_divisor  = (k == 2'd3) ? DIV_DIST : DIV_ANGLE;
  assign div_dividend = prod + 64'(div_divisor >> 1);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = (q_dout.opcode == OP_CLEAR) ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  state_next = ST_WAIT;
      ST_WAIT: begin
        if (div_done) state_next = (k == 2'd3) ? ST_TRIG_LOAD : ST_MUL;
      end
      ST_TRIG_LOAD: state_next = ST_FOLD;
      ST_FOLD: begin
        if (z <= PI_Q28 && z >= -PI_Q28) state_next = ST_ROT;
      end
      ST_ROT: begin
        if (ci == ATAN_IW'(CORDIC_STEPS - 1)) state_next = ST_TRIG_STORE;
      end
      ST_TRIG_STORE: state_next = trig_sel ? ST_MQ_LO : ST_TRIG_LOAD;
      ST_MQ_LO:  state_next = ST_MQ_HI;
      ST_MQ_HI:  state_next = ST_MQ_SUM;
      ST_MQ_SUM: state_next = (j == 2'd3) ? ST_OUT : ST_MQ_LO;
      ST_OUT: begin
        if (!out_valid || pop) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < 3; n++) begin
        off_angle[n] <= 32'sd0;
        off_pos[n]   <= 32'sd0;
      end
      k        <= 2'd0;
      j        <= 2'd0;
      ci       <= '0;
      flip     <= 1'b0;
      trig_sel <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            item <= q_dout;
            k    <= 2'd0;
            if (q_dout.opcode == OP_CLEAR) begin
              for (int n = 0; n < 3; n++) begin
                off_angle[n] <= 32'sd0;
                off_pos[n]   <= 32'sd0;
              end
            end
          end
        end
        ST_WAIT: begin
          if (div_done) begin
            if (k == 2'd3) begin
              d        <= qs[44:0];
              trig_sel <= 1'b0;
            end else begin
              off_angle[k] <= ang_sum;
              k            <= k + 2'd1;
            end
          end
        end
        ST_TRIG_LOAD: begin
          z    <= ta;
          x    <= GAIN_Q30;
          y    <= 34'sd0;
          ci   <= '0;
          flip <= 1'b0;
        end
        ST_FOLD: begin
          if (z > PI_Q28) z <= z - TWO_PI_Q28;
          else if (z < -PI_Q28) z <= z + TWO_PI_Q28;
          else if (z > HALF_PI_Q28) begin
            z    <= z - PI_Q28;
            flip <= 1'b1;
          end else if (z < -HALF_PI_Q28) begin
            z    <= z + PI_Q28;
            flip <= 1'b1;
          end
        end
        ST_ROT: begin
          if (z >= 35'sd0) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - at;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + at;
          end
          ci <= ci + 1'b1;
        end
        ST_TRIG_STORE: begin
          if (trig_sel) begin
            cy <= flip ? -x : x;
            sy <= flip ? -y : y;
            j  <= 2'd0;
          end else begin
            cp       <= flip ? -x : x;
            sp       <= flip ? -y : y;
            trig_sel <= 1'b1;
          end
        end
        ST_MQ_HI: lo_prod <= prod;
        ST_MQ_SUM: begin
          if (j == 2'd0) horiz <= r_s[48:0];
          else off_pos[pidx] <= sat32(64'(off_pos[pidx]) + r8_s);
          j <= j + 2'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || pop)) begin
      out_valid   <= 1'b1;
      guess_x     <= sat32(64'($signed(cfg[REG_X])) + 64'(off_pos[0]));
      guess_y     <= sat32(64'($signed(cfg[REG_Y])) + 64'(off_pos[1]));
      guess_z     <= sat32(64'($signed(cfg[REG_Z])) + 64'(off_pos[2]));
      guess_roll  <= sat32(64'($signed(cfg[REG_ROLL])) + 64'(off_angle[0]));
      guess_pitch <= sat32(64'($signed(cfg[REG_PITCH])) + 64'(off_angle[1]));
      guess_yaw   <= sat32(64'($signed(cfg[REG_YAW])) + 64'(off_angle[2]));
    end else if (pop && out_valid) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> design/gyro_odometry_pose_integrator_top.sv
// Top level of the gyro odometry pose integrator.
// Dead-reckoning pose: each integrate word adds rate*dt to the roll, pitch and yaw
// offsets and resolves speed*dt through CORDIC cos/sin of pitch and yaw into x, y, z
// offsets; the result is the reference pose plus saturated offsets. An integrate
// word runs four passes of the shared multiplier and the reciprocal constant
// divider, folds pitch and then yaw into range for a CORDIC run each, runs four
// split multiplies, and may wait for the result register to drain; a clear word
// skips all of these. A two-word input queue and the result register let input and
// output stall independently.
module gyro_odometry_pose_integrator_top #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               opcode,
  input  logic [31:0]        time_us,
  input  logic signed [31:0] rate_roll,
  input  logic signed [31:0] rate_pitch,
  input  logic signed [31:0] rate_yaw,
  input  logic signed [31:0] speed,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] guess_x,
  output logic signed [31:0] guess_y,
  output logic signed [31:0] guess_z,
  output logic signed [31:0] guess_roll,
  output logic signed [31:0] guess_pitch,
  output logic signed [31:0] guess_yaw,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import gopi_pkg::*;

  cfg_regs_t   cfg;
  logic        q_push, q_full, q_pop, q_empty;
  item_t       q_din, q_dout;
  logic        div_start, div_done;
  logic [63:0] div_dividend, div_quot;
  logic [19:0] div_divisor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready && cfg_index < 3'(NUM_REGS)) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  gopi_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .time_us(time_us), .rate_roll(rate_roll), .rate_pitch(rate_pitch),
    .rate_yaw(rate_yaw), .speed(speed), .q_full(q_full), .q_push(q_push),
    .q_din(q_din)
  );

  gopi_fifo u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .din(q_din), .full(q_full),
    .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );

  gopi_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quot(div_quot)
  );

  gopi_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_empty(q_empty), .q_dout(q_dout),
    .q_pop(q_pop), .div_start(div_start), .div_dividend(div_dividend),
    .div_divisor(div_divisor), .div_done(div_done), .div_quot(div_quot),
    .pop(pop), .empty(empty), .guess_x(guess_x), .guess_y(guess_y),
    .guess_z(guess_z), .guess_roll(guess_roll), .guess_pitch(guess_pitch),
    .guess_yaw(guess_yaw)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("queue read while empty");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> empty) else $error("result present after reset");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !div_done) else $error("divider done right after start");
`endif

endmodule
